// ===== hdl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int NIBBLE_W   = 4;
    localparam int ATTR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CHAR_W-1:0]   CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0]   CHAR_NEWLINE = 8'd10;
    localparam logic [COLOR_W-1:0]  COLOR_LIMIT  = 8'd16;
    localparam logic [NIBBLE_W-1:0] FG_DEFAULT   = 4'hC;
    localparam logic [NIBBLE_W-1:0] BG_DEFAULT   = 4'h0;

    typedef enum logic [1:0] {
        K_PRINT   = 2'd0,
        K_NEWLINE = 2'd1,
        K_TAB     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  char_code;
        logic [ATTR_W-1:0]  attr;
        logic               last_char;
    } t_item;

    typedef struct packed {
        logic               cell_write;
        logic [IDX_W-1:0]   cell_index;
        logic [CHAR_W-1:0]  cell_char;
        logic [ATTR_W-1:0]  cell_attr;
        logic               scroll_up;
        logic               cursor_valid;
        logic [ROW_W-1:0]   cursor_row;
        logic [COL_W-1:0]   cursor_col;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/tcw_front.sv =====
// Front end: classifies each character beat and builds its cell attribute.
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic [IN_DATA_W-1:0] i_tdata,
    input  wire logic                 i_tlast,
    output t_item                     o_item
);

    logic [CHAR_W-1:0]   w_char;
    logic [COLOR_W-1:0]  w_fg_raw;
    logic [COLOR_W-1:0]  w_bg_raw;
    logic [NIBBLE_W-1:0] w_fg;
    logic [NIBBLE_W-1:0] w_bg;

    assign w_char   = i_tdata[CHAR_W-1:0];
    assign w_fg_raw = i_tdata[CHAR_W+COLOR_W-1:CHAR_W];
    assign w_bg_raw = i_tdata[CHAR_W+2*COLOR_W-1:CHAR_W+COLOR_W];

    assign w_fg = (w_fg_raw >= COLOR_LIMIT) ? FG_DEFAULT : w_fg_raw[NIBBLE_W-1:0];
    assign w_bg = (w_bg_raw >= COLOR_LIMIT) ? BG_DEFAULT : w_bg_raw[NIBBLE_W-1:0];

    always_comb begin
        priority if (w_char == CHAR_NEWLINE) begin
            o_item.kind = K_NEWLINE;
        end else if (w_char == CHAR_TAB) begin
            o_item.kind = K_TAB;
        end else begin
            o_item.kind = K_PRINT;
        end
        o_item.char_code = w_char;
        o_item.attr      = {w_bg, w_fg};
        o_item.last_char = i_tlast;
    end

endmodule

`default_nettype wire

// ===== hdl/tcw_queue.sv =====
// Short queue of classified items between the front and back ends.
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_item i_push_item,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_item      o_pop_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];

    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tcw_back.sv =====
// Back end: moves the cursor, forms the cell write and holds the result beat.
`default_nettype none

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    output logic       o_item_ready,
    input  wire t_item i_item,
    output logic       o_res_valid,
    input  wire logic  i_res_ready,
    output t_result    o_res
);

    localparam int PH_W   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int FULL_W = ROW_W + COL_W + 1;

    logic [ROW_W-1:0] r_row,   n_row;
    logic [COL_W-1:0] r_col,   n_col;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic             r_res_valid;
    t_result          r_res, n_res;

    logic             w_take;
    logic [COL_W:0]   w_col_inc;
    logic [COL_W:0]   w_col_tab;
    logic [ROW_W:0]   w_row_inc;
    logic [PH_W-1:0]  w_phase_inc;
    logic [FULL_W-1:0] w_idx_full;
    logic             w_wrap;
    logic             w_scroll;

    assign o_item_ready = !r_res_valid || i_res_ready;
    assign w_take       = i_item_valid && o_item_ready;
    assign o_res_valid  = r_res_valid;
    assign o_res        = r_res;

    assign w_col_inc   = {1'b0, r_col} + (COL_W+1)'(1);
    assign w_col_tab   = {1'b0, r_col} + (COL_W+1)'(TAB_WIDTH) - (COL_W+1)'(r_phase);
    assign w_row_inc   = {1'b0, r_row} + (ROW_W+1)'(1);
    assign w_phase_inc = (r_phase == PH_W'(TAB_WIDTH - 1)) ? '0 : r_phase + PH_W'(1);
    assign w_idx_full  = FULL_W'(r_row) * FULL_W'(COLUMNS) + FULL_W'(r_col);

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_phase  = r_phase;
        w_wrap   = 1'b0;
        w_scroll = 1'b0;
        n_res    = '0;
        unique case (i_item.kind)
            K_NEWLINE: begin
                w_wrap = 1'b1;
            end
            K_TAB: begin
                if (w_col_tab >= (COL_W+1)'(COLUMNS)) begin
                    w_wrap = 1'b1;
                end else begin
                    n_col   = w_col_tab[COL_W-1:0];
                    n_phase = '0;
                end
            end
            K_PRINT: begin
                n_res.cell_write = 1'b1;
                n_res.cell_index = w_idx_full[IDX_W-1:0];
                n_res.cell_char  = i_item.char_code;
                n_res.cell_attr  = i_item.attr;
                if (w_col_inc >= (COL_W+1)'(COLUMNS)) begin
                    w_wrap = 1'b1;
                end else begin
                    n_col   = w_col_inc[COL_W-1:0];
                    n_phase = w_phase_inc;
                end
            end
            default: begin
                n_row = r_row;
            end
        endcase
        if (w_wrap) begin
            n_col   = '0;
            n_phase = '0;
            if (w_row_inc >= (ROW_W+1)'(ROWS)) begin
                w_scroll = 1'b1;
                n_row    = ROW_W'(ROWS - 1);
            end else begin
                n_row = w_row_inc[ROW_W-1:0];
            end
        end
        n_res.scroll_up    = w_scroll;
        n_res.cursor_valid = i_item.last_char;
        n_res.cursor_row   = n_row;
        n_res.cursor_col   = n_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_phase <= n_phase;
            end
            if (o_item_ready) begin
                r_res_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/text_console_writer_unit.sv =====
// Top level of the text console writer.
// Takes one character beat per clock while s_axis_tready is high and returns
// one result beat for each, in order; a beat waits in the queue and its result
// is registered in the back end. The rate is set by the cursor update in the
// back end, which takes an item whenever its result is free or being taken;
// a four-entry queue lets the input keep accepting while the output stalls,
// until it fills. Newline, tab and printable characters move the cursor over
// a COLUMNS by ROWS screen; moving past the last row raises scroll_up.
`default_nettype none

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // char_code[7:0], fg_color[15:8], bg_color[23:16]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // cell_index[10:0], cell_char[18:11], cell_attr[26:19], scroll_up[27],
    // cursor_row[32:28], cursor_col[39:33]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // cell_write[0]
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    t_item   w_front_item;
    t_item   w_queue_item;
    logic    w_queue_valid;
    logic    w_back_ready;
    t_result w_res;

    tcw_front u_front (
        .i_tdata (s_axis_tdata),
        .i_tlast (s_axis_tlast),
        .o_item  (w_front_item)
    );

    tcw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .o_push_ready (s_axis_tready),
        .i_push_item  (w_front_item),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_item   (w_queue_item)
    );

    tcw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_queue_valid),
        .o_item_ready (w_back_ready),
        .i_item       (w_queue_item),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (w_res)
    );

    assign m_axis_tdata = {w_res.cursor_col, w_res.cursor_row, w_res.scroll_up,
                           w_res.cell_attr, w_res.cell_char, w_res.cell_index};
    assign m_axis_tuser = w_res.cell_write;
    assign m_axis_tlast = w_res.cursor_valid;

endmodule

`default_nettype wire

// ===== verif/text_console_writer_unit_tb.sv =====
// Self-checking testbench for the text console writer: cursor, cell and scroll prediction.
`timescale 1ns / 1ps

import tcw_pkg::*;

module text_console_writer_unit_tb;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_WIDTH    = 4;
    localparam int RANDOM_CHARS = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;

    class cursor_tracker;
        t_result          pending[$];
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        int               errors;
        int               chars;
        int               writes;
        int               scrolls;
        int               cursor_updates;
        int               beats_seen;

        function new();
            row            = '0;
            col            = '0;
            errors         = 0;
            chars          = 0;
            writes         = 0;
            scrolls        = 0;
            cursor_updates = 0;
            beats_seen     = 0;
        endfunction

        task report(string field, longint got, longint want);
            $display("MISMATCH beat %0d %s: got %0h want %0h", beats_seen, field, got, want);
            errors++;
        endtask

        function logic next_row();
            col = '0;
            if (int'(row) + 1 >= ROWS) begin
                row = ROW_W'(ROWS - 1);
                return 1'b1;
            end
            row = row + 1'b1;
            return 1'b0;
        endfunction

        function void record_char(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg_in,
                                  logic [COLOR_W-1:0] bg_in, logic last);
            t_result             want;
            t_kind               kind;
            logic [NIBBLE_W-1:0] fg;
            logic [NIBBLE_W-1:0] bg;
            int                  idx;
            want = '0;
            fg   = (fg_in >= COLOR_LIMIT) ? FG_DEFAULT : fg_in[NIBBLE_W-1:0];
            bg   = (bg_in >= COLOR_LIMIT) ? BG_DEFAULT : bg_in[NIBBLE_W-1:0];
            kind = (ch == CHAR_NEWLINE) ? K_NEWLINE : (ch == CHAR_TAB) ? K_TAB : K_PRINT;
            case (kind)
                K_NEWLINE: begin
                    want.scroll_up = next_row();
                end
                K_TAB: begin
                    do col = col + 1'b1; while ((int'(col) % TAB_WIDTH) != 0);
                    if (int'(col) >= COLUMNS) want.scroll_up = next_row();
                end
                default: begin
                    idx             = int'(row) * COLUMNS + int'(col);
                    want.cell_write = 1'b1;
                    want.cell_index = idx[IDX_W-1:0];
                    want.cell_char  = ch;
                    want.cell_attr  = {bg, fg};
                    col             = col + 1'b1;
                    if (int'(col) >= COLUMNS) want.scroll_up = next_row();
                end
            endcase
            want.cursor_valid = last;
            want.cursor_row   = row;
            want.cursor_col   = col;
            chars++;
            writes         += want.cell_write;
            scrolls        += want.scroll_up;
            cursor_updates += last;
            pending.push_back(want);
        endfunction

        task check_update(t_result got);
            t_result want;
            beats_seen++;
            if (pending.size() == 0) begin
                report("unexpected beat", got, 0);
                return;
            end
            want = pending.pop_front();
            if (got.cell_write !== want.cell_write)
                report("cell_write", got.cell_write, want.cell_write);
            if (got.cell_index !== want.cell_index)
                report("cell_index", got.cell_index, want.cell_index);
            if (got.cell_char !== want.cell_char)
                report("cell_char", got.cell_char, want.cell_char);
            if (got.cell_attr !== want.cell_attr)
                report("cell_attr", got.cell_attr, want.cell_attr);
            if (got.scroll_up !== want.scroll_up)
                report("scroll_up", got.scroll_up, want.scroll_up);
            if (got.cursor_valid !== want.cursor_valid)
                report("cursor_valid", got.cursor_valid, want.cursor_valid);
            if (got.cursor_row !== want.cursor_row)
                report("cursor_row", got.cursor_row, want.cursor_row);
            if (got.cursor_col !== want.cursor_col)
                report("cursor_col", got.cursor_col, want.cursor_col);
        endtask
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic [IN_DATA_W-1:0]  s_data         = '0;
    logic                  s_last         = 1'b0;
    logic                  m_ready        = 1'b0;
    wire                   s_ready;
    wire                   m_valid;
    wire  [OUT_DATA_W-1:0] m_data;
    wire                   m_user;
    wire                   m_last;

    int cycle_count = 0;
    bit send_idle   = 1'b1;
    bit recv_idle   = 1'b1;
    int hold_reqs   = 0;
    int holds_done  = 0;

    cursor_tracker board;

    text_console_writer_unit #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    initial begin
        board = new();
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_char(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg,
                             logic [COLOR_W-1:0] bg, logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {bg, fg, ch};
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
        board.record_char(ch, fg, bg, last);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        return $urandom_range(0, 1) ? COLOR_W'($urandom_range(0, 15))
                                    : COLOR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: return (r < 8) ? CHAR_NEWLINE : (r < 16) ? CHAR_TAB
                                             : CHAR_W'($urandom_range(0, 255));
            1: return (r < 15) ? CHAR_TAB : CHAR_W'($urandom_range(32, 126));
            2: return (r < 35) ? CHAR_NEWLINE : (r < 45) ? CHAR_TAB
                                              : CHAR_W'($urandom_range(0, 255));
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        t_result got;
        wait (i_rst_n);
        forever begin
            if (holds_done < hold_reqs) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                int stall;
                stall = recv_idle ? $urandom_range(0, 5) : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            got.cell_write   = m_user;
            got.cell_index   = m_data[10:0];
            got.cell_char    = m_data[18:11];
            got.cell_attr    = m_data[26:19];
            got.scroll_up    = m_data[27];
            got.cursor_row   = m_data[32:28];
            got.cursor_col   = m_data[39:33];
            got.cursor_valid = m_last;
            board.check_update(got);
        end
    end

    initial begin
        int sent;
        int mode;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_char("A",   8'd0,   8'd0,   1'b0);
        send_char(8'hFF, 8'd15,  8'd15,  1'b0);
        send_char(8'h00, 8'd16,  8'd16,  1'b0);
        send_char("z",   8'd255, 8'd255, 1'b1);
        send_char(CHAR_TAB, 8'd3, 8'd4, 1'b0);
        send_char(CHAR_TAB, 8'd17, 8'd200, 1'b0);
        send_char(CHAR_NEWLINE, 8'd0, 8'd0, 1'b1);
        send_char(CHAR_TAB, 8'd1, 8'd2, 1'b0);
        send_char(8'h80, 8'h55, 8'hAA, 1'b0);
        send_char(8'h7F, 8'h0F, 8'hF0, 1'b1);
        send_char(CHAR_NEWLINE, 8'hFF, 8'hFF, 1'b0);
        send_char(8'h01, 8'h10, 8'h0F, 1'b0);
        send_char(8'h08, 8'h0F, 8'h10, 1'b0);
        send_char(8'h0B, 8'h08, 8'h07, 1'b0);
        send_char(8'hAA, 8'hAA, 8'h55, 1'b1);
        for (int i = 0; i < 5; i++) send_char(CHAR_TAB, 8'd7, 8'd1, i == 4);
        for (int i = 0; i < 5; i++) send_char(CHAR_NEWLINE, 8'd7, 8'd1, i == 4);

        sent = 0;
        while (sent < RANDOM_CHARS) begin
            mode      = $urandom_range(0, 5);
            mode      = (mode > 3) ? 0 : mode;
            len       = (mode == 1) ? $urandom_range(40, 120) : $urandom_range(1, 30);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if ((sent / 600) != ((sent + len) / 600)) hold_reqs++;
            for (int i = 0; i < len; i++) begin
                send_char(pick_char(mode), pick_color(), pick_color(),
                          (mode == 3) ? 1'($urandom_range(0, 1)) : (i == len - 1));
            end
            sent += len;
        end
        s_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending.size() != 0) board.report("results missing", board.pending.size(), 0);

        $display("Sent %0d characters: %0d cell writes, %0d scroll requests, %0d cursor updates",
                 board.chars, board.writes, board.scrolls, board.cursor_updates);
        $display("Output held off %0d times for %0d cycles; %0d mismatches",
                 holds_done, HOLD_CYCLES, board.errors);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer_unit.sv
verif/text_console_writer_unit_tb.sv
